@@ sv/vtsi_pkg.sv @@
package vtsi_pkg;

	localparam int COORD_BITS    = 16;
	localparam int ANGLE_BITS    = 16;
	localparam int MAX_SECTORS   = 64;
	localparam int CNT_BITS      = 7;
	localparam int IDX_BITS      = 6;
	localparam int CORD_W        = 64;
	localparam int Z_W           = 33;
	localparam int TURN_W        = 32;
	localparam int PRE_SHIFT     = 60 - COORD_BITS;
	localparam int ITERS         = 32;
	localparam int ITER_PER_STG  = 2;
	localparam int STAGES        = ITERS / ITER_PER_STG;
	localparam int PROD_W        = ANGLE_BITS + CNT_BITS;
	localparam int ADDR_BITS     = 3;

	localparam logic [TURN_W-1:0] EIGHTH_TURN  = 32'h2000_0000;
	localparam logic [TURN_W-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [TURN_W-1:0] HALF_TURN    = 32'h8000_0000;

	localparam logic [CNT_BITS-1:0] CNT_RESET = 7'd8;
	localparam logic [CNT_BITS-1:0] CNT_MAX   = CNT_BITS'(MAX_SECTORS);

	// register index within the config space (one register)
	localparam logic REG_SECTOR_COUNT = 1'b0;

	typedef struct packed {
		logic swap;     // octant was taken with x and y exchanged
		logic x_neg;
		logic x_zero;
		logic y_neg;
		logic y_zero;
	} quad_t;

	typedef struct packed {
		logic signed [CORD_W-1:0] x;
		logic signed [CORD_W-1:0] y;
		logic signed [Z_W-1:0]    z;
		quad_t                    quad;
	} cord_t;

	// round(atan(2^-i) * 2^32 / 2pi)
	function automatic logic [29:0] atan_val(input int i);
		logic [29:0] t;
		unique case (i)
			0:  t = 30'd536870912;
			1:  t = 30'd316933406;
			2:  t = 30'd167458907;
			3:  t = 30'd85004756;
			4:  t = 30'd42667331;
			5:  t = 30'd21354465;
			6:  t = 30'd10679838;
			7:  t = 30'd5340245;
			8:  t = 30'd2670163;
			9:  t = 30'd1335087;
			10: t = 30'd667544;
			11: t = 30'd333772;
			12: t = 30'd166886;
			13: t = 30'd83443;
			14: t = 30'd41722;
			15: t = 30'd20861;
			16: t = 30'd10430;
			17: t = 30'd5215;
			18: t = 30'd2608;
			19: t = 30'd1304;
			20: t = 30'd652;
			21: t = 30'd326;
			22: t = 30'd163;
			23: t = 30'd81;
			24: t = 30'd41;
			25: t = 30'd20;
			26: t = 30'd10;
			27: t = 30'd5;
			28: t = 30'd3;
			29: t = 30'd1;
			30: t = 30'd1;
			default: t = 30'd0;
		endcase
		return t;
	endfunction

	// shift that rounds toward zero for negative values
	function automatic logic signed [CORD_W-1:0] shr_sym(input logic signed [CORD_W-1:0] v,
			input int i);
		logic signed [CORD_W-1:0] n;
		n = -v;
		if (!v[CORD_W-1])
			return v >>> i;
		return -(n >>> i);
	endfunction

	// one vectoring rotation; a word whose y reached zero passes unchanged
	function automatic cord_t cord_iter(input cord_t c, input int i);
		cord_t r;
		logic signed [Z_W-1:0] t;
		r = c;
		t = $signed({3'b000, atan_val(i)});
		if (c.y != '0) begin
			if (!c.y[CORD_W-1]) begin
				r.x = c.x + shr_sym(c.y, i);
				r.y = c.y - shr_sym(c.x, i);
				r.z = c.z + t;
			end else begin
				r.x = c.x - shr_sym(c.y, i);
				r.y = c.y + shr_sym(c.x, i);
				r.z = c.z - t;
			end
		end
		return r;
	endfunction

endpackage

@@ sv/vtsi_prep.sv @@
module vtsi_prep
	import vtsi_pkg::*;
(
	input  logic signed [COORD_BITS-1:0] aim_x,
	input  logic signed [COORD_BITS-1:0] aim_y,
	output cord_t                        cord
);

	logic [COORD_BITS:0] ax, ay, hi, lo;
	logic                swap;

	always_comb begin
		ax   = aim_x[COORD_BITS-1] ? (COORD_BITS+1)'(-$signed({aim_x[COORD_BITS-1], aim_x}))
		                           : {1'b0, aim_x};
		ay   = aim_y[COORD_BITS-1] ? (COORD_BITS+1)'(-$signed({aim_y[COORD_BITS-1], aim_y}))
		                           : {1'b0, aim_y};
		swap = ay > ax;
		hi   = swap ? ay : ax;
		lo   = swap ? ax : ay;

		cord.quad.swap   = swap;
		cord.quad.x_neg  = aim_x[COORD_BITS-1];
		cord.quad.x_zero = (aim_x == '0);
		cord.quad.y_neg  = aim_y[COORD_BITS-1];
		cord.quad.y_zero = (aim_y == '0);

		cord.x = $signed(CORD_W'(hi) << PRE_SHIFT);
		cord.y = $signed(CORD_W'(lo) << PRE_SHIFT);
		cord.z = '0;
		// diagonal is exact: skip the rotations
		if (lo == hi && lo != '0) begin
			cord.y = '0;
			cord.z = $signed({1'b0, EIGHTH_TURN});
		end
	end

endmodule

@@ sv/vtsi_cordic.sv @@
module vtsi_cordic
	import vtsi_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_v,
	output logic  in_rdy,
	input  cord_t in_d,
	output logic  out_v,
	input  logic  out_rdy,
	output cord_t out_d
);

	logic  [STAGES:0]   vld_s;
	cord_t              st_s  [STAGES+1];
	logic  [STAGES+1:0] rdy;
	logic  [STAGES:0]   src_v;
	cord_t              src_d [STAGES+1];

	assign rdy[STAGES+1] = out_rdy;
	assign in_rdy        = rdy[0];
	assign out_v         = vld_s[STAGES];
	assign out_d         = st_s[STAGES];

	for (genvar k = 0; k <= STAGES; k++) begin : g_stage
		if (k == 0) begin : g_entry
			assign src_v[k] = in_v;
			assign src_d[k] = in_d;
		end else begin : g_rot
			assign src_v[k] = vld_s[k-1];
			assign src_d[k] = cord_iter(cord_iter(st_s[k-1], ITER_PER_STG*(k-1)),
			                            ITER_PER_STG*(k-1)+1);
		end

		// a stage takes a word when it is empty or its word moves on
		assign rdy[k] = ~vld_s[k] | rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= src_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && src_v[k]) begin
				st_s[k] <= src_d[k];
			end
		end
	end

endmodule

@@ sv/vtsi_finish.sv @@
module vtsi_finish
	import vtsi_pkg::*;
(
	input  cord_t                cord,
	input  logic [CNT_BITS-1:0]  sector_count,
	output logic [IDX_BITS-1:0]  sector_index,
	output logic                 valid_res
);

	logic [TURN_W-1:0]     z, q, turn;
	logic [ANGLE_BITS-1:0] ang;
	logic [CNT_BITS-1:0]   cnt, idx;
	logic [PROD_W-1:0]     prod;
	quad_t                 qd;

	always_comb begin
		qd = cord.quad;

		// clamp to the octant
		if (cord.z[Z_W-1])
			z = '0;
		else if (cord.z > $signed({1'b0, EIGHTH_TURN}))
			z = EIGHTH_TURN;
		else
			z = cord.z[TURN_W-1:0];

		q = qd.swap ? QUARTER_TURN - z : z;

		priority if (!qd.x_neg && !qd.x_zero && !qd.y_neg)
			turn = q;
		else if ((qd.x_neg || qd.x_zero) && !qd.y_neg && !qd.y_zero)
			turn = HALF_TURN - q;
		else if (qd.x_neg && (qd.y_neg || qd.y_zero))
			turn = HALF_TURN + q;
		else
			turn = '0 - q;

		// rotate so that straight down is zero
		ang = turn[TURN_W-1 -: ANGLE_BITS] + ANGLE_BITS'(1 << (ANGLE_BITS-2));

		cnt  = (sector_count > CNT_MAX) ? CNT_MAX : sector_count;
		prod = PROD_W'(ang) * PROD_W'(cnt) + PROD_W'(1 << (ANGLE_BITS-1));
		idx  = prod[PROD_W-1 -: CNT_BITS];
		// rounding can land on count itself, which wraps to zero
		if (idx == cnt)
			idx = '0;

		valid_res    = (cnt != '0) && !(qd.x_zero && qd.y_zero);
		sector_index = valid_res ? idx[IDX_BITS-1:0] : '0;
	end

endmodule

@@ sv/vector_to_sector_index.sv @@
// Angle sector quantizer: signed aim vector in, sector index out.
// A word accepted on the aim side passes through the input register, the octant fold,
// 16 two-step rotation stages and the output register before it reaches the result side.
// Throughput: one word per cycle while res_stall is low; each stage moves on its own.
// Reset: pipeline and output valids clear; sector_count returns to 8.
module vector_to_sector_index
	import vtsi_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ADDR_BITS-1:0]         paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,

	input  logic                         aim_valid,
	output logic                         aim_stall,
	input  logic signed [COORD_BITS-1:0] aim_x,
	input  logic signed [COORD_BITS-1:0] aim_y,

	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [IDX_BITS-1:0]          sector_index,
	output logic                         valid_res
);

	logic [CNT_BITS-1:0]          sector_count_q;
	logic                         v_s1;
	logic signed [COORD_BITS-1:0] aim_x_s1, aim_y_s1;
	logic                         rdy_s1, cord_rdy, out_rdy;
	cord_t                        prep_d, cord_out;
	logic                         cord_v;
	logic [IDX_BITS-1:0]          idx_c;
	logic                         vres_c;
	logic                         res_valid_q;
	logic [IDX_BITS-1:0]          sector_index_q;
	logic                         valid_res_q;

	// config register
	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_BITS-1] == REG_SECTOR_COUNT) ? 32'(sector_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_count_q <= CNT_RESET;
		end else if (psel && penable && pwrite && paddr[ADDR_BITS-1] == REG_SECTOR_COUNT) begin
			sector_count_q <= pwdata[CNT_BITS-1:0];
		end
	end

	// input register
	assign rdy_s1    = ~v_s1 | cord_rdy;
	assign aim_stall = ~rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= aim_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && aim_valid) begin
			aim_x_s1 <= aim_x;
			aim_y_s1 <= aim_y;
		end
	end

	vtsi_prep u_prep (
		.aim_x (aim_x_s1),
		.aim_y (aim_y_s1),
		.cord  (prep_d)
	);

	vtsi_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (v_s1),
		.in_rdy  (cord_rdy),
		.in_d    (prep_d),
		.out_v   (cord_v),
		.out_rdy (out_rdy),
		.out_d   (cord_out)
	);

	vtsi_finish u_finish (
		.cord         (cord_out),
		.sector_count (sector_count_q),
		.sector_index (idx_c),
		.valid_res    (vres_c)
	);

	// output register
	assign out_rdy = ~res_valid_q | ~res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_rdy) begin
			res_valid_q <= cord_v;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && cord_v) begin
			sector_index_q <= idx_c;
			valid_res_q    <= vres_c;
		end
	end

	assign res_valid    = res_valid_q;
	assign sector_index = sector_index_q;
	assign valid_res    = valid_res_q;

endmodule
